// ===== hw/rtl/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// Path rule substring matcher package
// Word types, operation and status codes, character constants and the
// sequencer state type that the matcher uses.
// ----------------------------------------------------------------------------
package psm_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic       last_byte;
    logic [5:0] rule_index;
    logic [6:0] char_position;
  } psm_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       hit;
    logic [7:0] read_char;
    logic [6:0] read_length;
    logic [6:0] rules_held;
  } psm_out_t;

  localparam logic [1:0] OP_LINE = 2'd0;
  localparam logic [1:0] OP_PATH = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_INVALID   = 3'd1;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LINE,
    S_FIND,
    S_DEL,
    S_ADD,
    S_PATH,
    S_CLEAR,
    S_READ,
    S_DONE
  } psm_state_t;

endpackage

// ===== hw/rtl/path_rule_substring_matcher.sv =====
// A path byte before any NUL is checked against every rule row; the last path byte is followed
// by a sweep that clears the partial matches and yields the result. A valid final command byte
// starts a rule search, then an add or a delete that shifts later rows down; a read looks up a row.
// Throughput is set by the rule table read port, one rule row per cycle while a scan runs;
// no input word is taken until the sequencer is idle. Reset empties the table by zeroing the
// rule count and clears the sequencer state, counters and match flags; no clearing pass runs.
// ----------------------------------------------------------------------------
// Path rule substring matcher
// Holds a table of text rules edited by command lines, tracks partial matches
// of a streamed path against every rule, and answers reads of rule text.
// ----------------------------------------------------------------------------
module path_rule_substring_matcher #(
  parameter int MAX_RULES  = 64,
  parameter int RULE_BYTES = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  psm_pkg::psm_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output psm_pkg::psm_out_t out_word
);

  localparam int RW    = $clog2(MAX_RULES + 1);
  localparam int AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int LW    = $clog2(RULE_BYTES + 1);
  localparam int LNW   = $clog2(RULE_BYTES);
  localparam int TW    = 8 * RULE_BYTES;
  localparam int ROW_W = LNW + RULE_BYTES + TW;

  logic [ROW_W-1:0] mem [MAX_RULES];
  logic [ROW_W-1:0] mem_rd_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [AW-1:0]    mem_ra;
  logic [ROW_W-1:0] mem_wd;

  psm_pkg::psm_state_t state_r, state_nxt;
  logic [RW-1:0]  total_r, total_nxt;
  logic [RW-1:0]  ptr_r, ptr_nxt;
  logic           dv_r, dv_nxt;
  logic [AW-1:0]  dptr_r, dptr_nxt;
  logic [LW-1:0]  len_cnt_r, len_cnt_nxt;
  logic           ovf_r, ovf_nxt;
  logic [LW-1:0]  nend_r, nend_nxt;
  logic           zseen_r, zseen_nxt;
  logic [LW-1:0]  zpos_r, zpos_nxt;
  logic [TW-1:0]  line_r, line_nxt;
  logic [7:0]     cbyte_r, cbyte_nxt;
  logic           plast_r, plast_nxt;
  logic           stopped_r, stopped_nxt;
  logic           pfound_r, pfound_nxt;
  logic           start_r, start_nxt;
  logic [LNW-1:0] cand_len_r, cand_len_nxt;
  logic           del_r, del_nxt;
  logic           found_r, found_nxt;
  logic [AW-1:0]  fidx_r, fidx_nxt;
  logic [5:0]     ridx_r, ridx_nxt;
  logic [6:0]     rpos_r, rpos_nxt;
  psm_pkg::psm_out_t res_r, res_nxt;
  psm_pkg::psm_out_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [LNW-1:0]        rd_len;
  logic [RULE_BYTES-1:0] rd_pm;
  logic [TW-1:0]         rd_text;
  logic [RULE_BYTES-1:0] new_pm;
  logic [LNW-1:0]        hit_pos;
  logic                  path_hit;
  logic [TW-1:0]         cand_text;
  logic                  cand_eq;
  logic [LW-1:0]         m_val;
  logic [7:0]            buf0;
  logic                  start_v;
  logic [LW-1:0]         slen_v;
  logic                  scan_issue;
  logic                  scan_end;
  logic                  read_ok;
  logic                  char_ok;
  logic [LNW-1:0]        rpos_idx;

  assign rd_len  = mem_rd_r[ROW_W-1 -: LNW];
  assign rd_pm   = mem_rd_r[TW +: RULE_BYTES];
  assign rd_text = mem_rd_r[0 +: TW];

  always_comb begin
    new_pm[0] = (rd_text[7:0] == cbyte_r);
    for (int j = 1; j < RULE_BYTES; j++) begin
      new_pm[j] = (rd_text[8*j +: 8] == cbyte_r) && rd_pm[j-1];
    end
  end

  assign hit_pos  = rd_len - LNW'(1);
  assign path_hit = new_pm[hit_pos];

  assign cand_text = start_r ? (line_r >> 8) : line_r;

  always_comb begin
    cand_eq = (rd_len == cand_len_r);
    for (int j = 0; j < RULE_BYTES; j++) begin
      if ((j < int'(cand_len_r)) && (rd_text[8*j +: 8] != cand_text[8*j +: 8])) begin
        cand_eq = 1'b0;
      end
    end
  end

  assign m_val   = (zseen_r && (zpos_r < nend_r)) ? zpos_r : nend_r;
  assign buf0    = line_r[7:0];
  assign start_v = (m_val != '0) && ((buf0 == psm_pkg::CH_TILDE) || (buf0 == psm_pkg::CH_PLUS));
  assign slen_v  = m_val - LW'(start_v);

  assign scan_issue = (ptr_r < total_r);
  assign scan_end   = !scan_issue && !dv_r;

  assign read_ok  = ({{RW{1'b0}}, ridx_r} < {6'd0, total_r});
  assign char_ok  = read_ok && ({{LNW{1'b0}}, rpos_r} < {7'd0, rd_len});
  assign rpos_idx = LNW'(rpos_r);

  assign in_stall  = (state_r != psm_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    ptr_nxt       = ptr_r;
    dv_nxt        = 1'b0;
    dptr_nxt      = dptr_r;
    len_cnt_nxt   = len_cnt_r;
    ovf_nxt       = ovf_r;
    nend_nxt      = nend_r;
    zseen_nxt     = zseen_r;
    zpos_nxt      = zpos_r;
    line_nxt      = line_r;
    cbyte_nxt     = cbyte_r;
    plast_nxt     = plast_r;
    stopped_nxt   = stopped_r;
    pfound_nxt    = pfound_r;
    start_nxt     = start_r;
    cand_len_nxt  = cand_len_r;
    del_nxt       = del_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    ridx_nxt      = ridx_r;
    rpos_nxt      = rpos_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_wa        = dptr_r;
    mem_wd        = mem_rd_r;
    mem_ra        = AW'(in_word.rule_index);

    if ((state_r == psm_pkg::S_FIND) || (state_r == psm_pkg::S_DEL) ||
        (state_r == psm_pkg::S_PATH) || (state_r == psm_pkg::S_CLEAR)) begin
      mem_ra = AW'(ptr_r);
      if (scan_issue) begin
        dv_nxt   = 1'b1;
        dptr_nxt = AW'(ptr_r);
        ptr_nxt  = ptr_r + RW'(1);
      end
    end

    case (state_r)
      psm_pkg::S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          case (in_word.operation)
            psm_pkg::OP_LINE: begin
              if (len_cnt_r < LW'(RULE_BYTES)) begin
                line_nxt[8*LNW'(len_cnt_r) +: 8] = in_word.byte_value;
                len_cnt_nxt = len_cnt_r + LW'(1);
                if ((in_word.byte_value != psm_pkg::CH_LF) &&
                    (in_word.byte_value != psm_pkg::CH_CR)) begin
                  nend_nxt = len_cnt_r + LW'(1);
                end
                if ((in_word.byte_value == psm_pkg::CH_NUL) && !zseen_r) begin
                  zseen_nxt = 1'b1;
                  zpos_nxt  = len_cnt_r;
                end
              end else begin
                ovf_nxt = 1'b1;
              end
              if (in_word.last_byte) begin
                state_nxt = psm_pkg::S_LINE;
              end
            end
            psm_pkg::OP_PATH: begin
              if (in_word.byte_value == psm_pkg::CH_NUL) begin
                stopped_nxt = 1'b1;
              end
              ptr_nxt = '0;
              plast_nxt = in_word.last_byte;
              if (!stopped_r && (in_word.byte_value != psm_pkg::CH_NUL)) begin
                cbyte_nxt = in_word.byte_value;
                state_nxt = psm_pkg::S_PATH;
              end else if (in_word.last_byte) begin
                state_nxt = psm_pkg::S_CLEAR;
              end
            end
            psm_pkg::OP_READ: begin
              ridx_nxt  = in_word.rule_index;
              rpos_nxt  = in_word.char_position;
              state_nxt = psm_pkg::S_READ;
            end
            default: begin
            end
          endcase
        end
      end

      psm_pkg::S_LINE: begin
        len_cnt_nxt = '0;
        ovf_nxt     = 1'b0;
        nend_nxt    = '0;
        zseen_nxt   = 1'b0;
        start_nxt   = start_v;
        del_nxt     = start_v && (buf0 == psm_pkg::CH_TILDE);
        cand_len_nxt = LNW'(slen_v);
        state_nxt   = psm_pkg::S_DONE;
        res_nxt.status = psm_pkg::STAT_OK;
        if (ovf_r) begin
          res_nxt.status = psm_pkg::STAT_TOO_LONG;
        end else if (nend_r == '0) begin
          res_nxt.status = psm_pkg::STAT_OK;
        end else if ((m_val == LW'(1)) && (buf0 == psm_pkg::CH_MINUS)) begin
          total_nxt = '0;
        end else if (slen_v == '0) begin
          res_nxt.status = psm_pkg::STAT_INVALID;
        end else if (slen_v >= LW'(RULE_BYTES)) begin
          res_nxt.status = psm_pkg::STAT_TOO_LONG;
        end else begin
          ptr_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = psm_pkg::S_FIND;
        end
      end

      psm_pkg::S_FIND: begin
        if (dv_r && cand_eq && !found_r) begin
          found_nxt = 1'b1;
          fidx_nxt  = dptr_r;
        end
        if (scan_end) begin
          state_nxt = psm_pkg::S_DONE;
          if (del_r) begin
            if (!found_r) begin
              res_nxt.status = psm_pkg::STAT_NOT_FOUND;
            end else begin
              ptr_nxt   = RW'(fidx_r) + RW'(1);
              state_nxt = psm_pkg::S_DEL;
            end
          end else if (!found_r) begin
            if (total_r >= RW'(MAX_RULES)) begin
              res_nxt.status = psm_pkg::STAT_FULL;
            end else begin
              state_nxt = psm_pkg::S_ADD;
            end
          end
        end
      end

      psm_pkg::S_DEL: begin
        if (dv_r) begin
          mem_we = 1'b1;
          mem_wa = dptr_r - AW'(1);
          mem_wd = mem_rd_r;
        end
        if (scan_end) begin
          total_nxt = total_r - RW'(1);
          state_nxt = psm_pkg::S_DONE;
        end
      end

      psm_pkg::S_ADD: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(total_r);
        mem_wd    = {cand_len_r, {RULE_BYTES{1'b0}}, cand_text};
        total_nxt = total_r + RW'(1);
        state_nxt = psm_pkg::S_DONE;
      end

      psm_pkg::S_PATH: begin
        if (dv_r) begin
          mem_we = 1'b1;
          mem_wa = dptr_r;
          mem_wd = {rd_len, new_pm, rd_text};
          if (path_hit) begin
            pfound_nxt = 1'b1;
          end
        end
        if (scan_end) begin
          ptr_nxt   = '0;
          state_nxt = plast_r ? psm_pkg::S_CLEAR : psm_pkg::S_IDLE;
        end
      end

      psm_pkg::S_CLEAR: begin
        if (dv_r) begin
          mem_we = 1'b1;
          mem_wa = dptr_r;
          mem_wd = {rd_len, {RULE_BYTES{1'b0}}, rd_text};
        end
        if (scan_end) begin
          res_nxt.hit = pfound_r;
          pfound_nxt  = 1'b0;
          stopped_nxt = 1'b0;
          state_nxt   = psm_pkg::S_DONE;
        end
      end

      psm_pkg::S_READ: begin
        res_nxt.read_length = read_ok ? 7'(rd_len) : 7'd0;
        res_nxt.read_char   = char_ok ? rd_text[8*rpos_idx +: 8] : 8'd0;
        state_nxt           = psm_pkg::S_DONE;
      end

      psm_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt            = res_r;
          out_nxt.rules_held = 7'(total_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = psm_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = psm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psm_pkg::S_IDLE;
      total_r     <= '0;
      ptr_r       <= '0;
      dv_r        <= 1'b0;
      len_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      nend_r      <= '0;
      zseen_r     <= 1'b0;
      stopped_r   <= 1'b0;
      pfound_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      ptr_r       <= ptr_nxt;
      dv_r        <= dv_nxt;
      len_cnt_r   <= len_cnt_nxt;
      ovf_r       <= ovf_nxt;
      nend_r      <= nend_nxt;
      zseen_r     <= zseen_nxt;
      stopped_r   <= stopped_nxt;
      pfound_r    <= pfound_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dptr_r     <= dptr_nxt;
    zpos_r     <= zpos_nxt;
    line_r     <= line_nxt;
    cbyte_r    <= cbyte_nxt;
    plast_r    <= plast_nxt;
    start_r    <= start_nxt;
    cand_len_r <= cand_len_nxt;
    del_r      <= del_nxt;
    fidx_r     <= fidx_nxt;
    ridx_r     <= ridx_nxt;
    rpos_r     <= rpos_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

endmodule
